[hdl/swsnd_pkg.sv]
package swsnd_pkg;

	localparam int SEQ_BITS     = 16;
	localparam int PAYLOAD_BITS = 64;
	localparam int WSIZE_BITS   = 6;
	localparam int CFG_BITS     = 16;

	localparam logic [1:0] REQ_SEND    = 2'd0;
	localparam logic [1:0] REQ_ACK     = 2'd1;
	localparam logic [1:0] REQ_TIMEOUT = 2'd2;

	localparam logic CFG_INITIAL_SEQ = 1'b0;
	localparam logic CFG_WINDOW_SIZE = 1'b1;

	localparam logic [1:0] DUP_LIMIT = 2'd3;
	localparam logic [WSIZE_BITS-1:0] WSIZE_RESET = 6'd4;

	typedef struct packed {
		logic [1:0]              req_type;
		logic [PAYLOAD_BITS-1:0] payload;
		logic [SEQ_BITS-1:0]     ack_number;
		logic                    ack_valid;
	} item_t;

	typedef struct packed {
		logic                    accepted;
		logic                    pkt_valid;
		logic [SEQ_BITS-1:0]     pkt_seq;
		logic [PAYLOAD_BITS-1:0] pkt_payload;
		logic                    timer_start;
		logic                    timer_stop;
		logic                    last;
	} result_t;

endpackage

[hdl/swsnd_buf.sv]
module swsnd_buf #(
	parameter int DEPTH = 32,
	parameter int AW    = 5,
	parameter int DW    = 64
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

[hdl/sliding_window_sender.sv]
// channel  | handshake            | payload
// ---------+----------------------+---------------------------
// request  | start, busy          | item   (swsnd_pkg::item_t)
// result   | done (one per result) | result (swsnd_pkg::result_t)
// config   | cfg_we               | cfg_index, cfg_data
//
// A request is taken when start is high and busy low; busy is then high while it runs.
// Send, ack and unknown requests: take, then execute; one result the cycle after.
// Timeout: one result per outstanding packet (at least one), one result per cycle,
// paced by the single read port of the payload buffer.
// Reset clears window state at once; the payload buffer needs no clearing pass.
// The receiver cannot stall: each result is valid for exactly the cycle done is high.
module sliding_window_sender #(
	parameter int WINDOW_MAX = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  swsnd_pkg::item_t                      item,
	input  logic                                  cfg_we,
	input  logic                                  cfg_index,
	input  logic [swsnd_pkg::CFG_BITS-1:0]        cfg_data,
	output logic                                  done,
	output swsnd_pkg::result_t                    result
);

	localparam int SB = swsnd_pkg::SEQ_BITS;
	localparam int PB = swsnd_pkg::PAYLOAD_BITS;
	localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int CW = $clog2(WINDOW_MAX + 1);
	localparam logic [AW-1:0] LAST_ADDR = AW'(WINDOW_MAX - 1);
	localparam logic [AW:0]   DEPTH_W   = (AW + 1)'(WINDOW_MAX);
	localparam logic [SB-1:0] WMAX_SEQ  = SB'(WINDOW_MAX);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_EXEC = 3'b010,
		ST_TOUT = 3'b100
	} state_t;

	state_t             state_q, state_d;
	swsnd_pkg::item_t   item_q;
	swsnd_pkg::result_t result_q, result_d;
	logic               done_q, done_d;
	logic [SB-1:0]      base_q, base_d;
	logic [SB-1:0]      next_q, next_d;
	logic [1:0]         dup_q, dup_d;
	logic [AW-1:0]      head_q, head_d;
	logic [AW-1:0]      ptr_q, ptr_d;
	logic [CW-1:0]      idx_q, idx_d;
	logic [CW-1:0]      cnt_q, cnt_d;
	logic [swsnd_pkg::WSIZE_BITS-1:0] wsize_q;

	logic [SB-1:0] outs_c, eff_c, off_c, outs_new_c, ack_next_c;
	logic [AW:0]   wsum_c, hsum_c;
	logic [AW-1:0] waddr_c, head_adv_c, head_inc_c, ptr_inc_c, raddr_c;
	logic [PB-1:0] rdata;
	logic          we_c, full_c, adv_c, dup_hit_c, resend_c;
	logic [CW-1:0] tcnt_c;

	assign outs_c = next_q - base_q;
	assign eff_c  = (wsize_q == '0) ? SB'(1) :
		((SB'(wsize_q) > WMAX_SEQ) ? WMAX_SEQ : SB'(wsize_q));
	assign full_c = (outs_c >= eff_c) || (outs_c >= WMAX_SEQ);

	// ring address of entry at offset outs from base
	assign wsum_c  = {1'b0, head_q} + outs_c[AW:0];
	assign waddr_c = (wsum_c >= DEPTH_W) ? AW'(wsum_c - DEPTH_W) : wsum_c[AW-1:0];

	assign off_c      = item_q.ack_number - base_q;
	assign ack_next_c = item_q.ack_number + SB'(1);
	assign adv_c      = item_q.ack_valid && (off_c < outs_c);
	assign dup_hit_c  = item_q.ack_valid && (item_q.ack_number == base_q - SB'(1));
	assign resend_c   = !adv_c && dup_hit_c && (dup_q == swsnd_pkg::DUP_LIMIT - 2'd1)
		&& (outs_c != '0);
	assign outs_new_c = adv_c ? (next_q - ack_next_c) : outs_c;
	assign hsum_c     = {1'b0, head_q} + off_c[AW:0] + (AW + 1)'(1);
	assign head_adv_c = (hsum_c >= DEPTH_W) ? AW'(hsum_c - DEPTH_W) : hsum_c[AW-1:0];

	assign head_inc_c = (head_q == LAST_ADDR) ? '0 : head_q + AW'(1);
	assign ptr_inc_c  = (ptr_q == LAST_ADDR) ? '0 : ptr_q + AW'(1);
	assign tcnt_c     = (outs_c > WMAX_SEQ) ? CW'(WINDOW_MAX) : outs_c[CW-1:0];

	always_comb begin
		unique case (state_q)
			ST_IDLE: raddr_c = head_q;
			ST_EXEC: raddr_c = head_inc_c;
			ST_TOUT: raddr_c = ptr_inc_c;
			default: raddr_c = head_q;
		endcase
	end

	always_comb begin
		state_d  = state_q;
		result_d = '0;
		done_d   = 1'b0;
		base_d   = base_q;
		next_d   = next_q;
		dup_d    = dup_q;
		head_d   = head_q;
		ptr_d    = ptr_q;
		idx_d    = idx_q;
		cnt_d    = cnt_q;
		we_c     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				done_d        = 1'b1;
				result_d.last = 1'b1;
				state_d       = ST_IDLE;
				unique case (item_q.req_type)
					swsnd_pkg::REQ_SEND: begin
						if (!full_c) begin
							we_c                 = 1'b1;
							result_d.accepted    = 1'b1;
							result_d.pkt_valid   = 1'b1;
							result_d.pkt_seq     = next_q;
							result_d.pkt_payload = item_q.payload;
							result_d.timer_start = (outs_c == '0);
							next_d               = next_q + SB'(1);
						end
					end
					swsnd_pkg::REQ_ACK: begin
						if (adv_c) begin
							base_d = ack_next_c;
							head_d = head_adv_c;
							dup_d  = 2'd1;
						end else if (dup_hit_c && dup_q != swsnd_pkg::DUP_LIMIT) begin
							dup_d = dup_q + 2'd1;
						end
						if (resend_c) begin
							result_d.pkt_valid   = 1'b1;
							result_d.pkt_seq     = base_q;
							result_d.pkt_payload = rdata;
						end
						result_d.timer_start = (outs_new_c != '0);
						result_d.timer_stop  = (outs_new_c == '0);
					end
					swsnd_pkg::REQ_TIMEOUT: begin
						result_d.timer_start = 1'b1;
						if (outs_c != '0) begin
							result_d.pkt_valid   = 1'b1;
							result_d.pkt_seq     = base_q;
							result_d.pkt_payload = rdata;
							result_d.last        = (tcnt_c == CW'(1));
							cnt_d                = tcnt_c;
							idx_d                = CW'(1);
							ptr_d                = head_inc_c;
							if (tcnt_c != CW'(1)) begin
								state_d = ST_TOUT;
							end
						end
					end
					default: begin
					end
				endcase
			end
			ST_TOUT: begin
				done_d               = 1'b1;
				result_d.pkt_valid   = 1'b1;
				result_d.pkt_seq     = base_q + SB'(idx_q);
				result_d.pkt_payload = rdata;
				result_d.last        = (idx_q + CW'(1) == cnt_q);
				idx_d                = idx_q + CW'(1);
				ptr_d                = ptr_inc_c;
				if (result_d.last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
			base_q  <= '0;
			next_q  <= '0;
			dup_q   <= '0;
			head_q  <= '0;
			wsize_q <= swsnd_pkg::WSIZE_RESET;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
			head_q  <= head_d;
			if (cfg_we && cfg_index == swsnd_pkg::CFG_INITIAL_SEQ) begin
				base_q <= cfg_data[SB-1:0];
				next_q <= cfg_data[SB-1:0];
				dup_q  <= '0;
			end else begin
				base_q <= base_d;
				next_q <= next_d;
				dup_q  <= dup_d;
			end
			if (cfg_we && cfg_index == swsnd_pkg::CFG_WINDOW_SIZE) begin
				wsize_q <= cfg_data[swsnd_pkg::WSIZE_BITS-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		result_q <= result_d;
		ptr_q    <= ptr_d;
		idx_q    <= idx_d;
		cnt_q    <= cnt_d;
		if (state_q == ST_IDLE && start) begin
			item_q <= item;
		end
	end

	swsnd_buf #(
		.DEPTH(WINDOW_MAX),
		.AW   (AW),
		.DW   (PB)
	) u_buf (
		.clk  (clk),
		.we   (we_c),
		.waddr(waddr_c),
		.wdata(item_q.payload),
		.raddr(raddr_c),
		.rdata(rdata)
	);

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

	a_done_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(state_q) == ST_EXEC || $past(state_q) == ST_TOUT))
		else $error("result strobe without work");

	a_last_on_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> (done && result.last))
		else $error("request finished without final result");

	a_window_bound: assert property (@(posedge clk) disable iff (!arst_n)
		outs_c <= WMAX_SEQ)
		else $error("outstanding count beyond buffer depth");

	a_accept_has_pkt: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.accepted) |-> (result.pkt_valid && result.last))
		else $error("accepted send without packet");

endmodule
